### rtl/core/ffea_pkg.sv
package ffea_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PADDR_W = 3;

    typedef enum logic [1:0] {
        ACT_REG   = 2'd0,
        ACT_UNREG = 2'd1,
        ACT_FIND  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NO_FIT    = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_PLACE,
        S_DEL_SCAN,
        S_DEL_SHIFT,
        S_FIND_FIRST,
        S_FIND_STEP,
        S_FIND_TAIL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] start_req;
        logic [31:0] length;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [32:0]      fit_start;
        logic [CNT_W-1:0] used_count;
    } t_out;

    typedef struct packed {
        logic [31:0] first;
        logic [32:0] stop;
    } t_entry;

    typedef struct packed {
        logic    load;
        logic    rd_next;
        logic    rd_prev;
        logic    idx_inc;
        logic    idx_dec;
        logic    shift_up;
        logic    shift_down;
        logic    place;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    run_first;
        logic    run_step;
        logic    fit_take;
        logic    emit;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic idx_last;
        logic idx_zero;
        logic ins_move;
        logic del_match;
        logic overlap;
        logic gap_fit;
        logic tail_fit;
        logic out_free;
    } t_stat;

endpackage

### rtl/core/ffea_ctrl.sv
module ffea_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_action,
    input  ffea_pkg::t_stat i_stat,
    output ffea_pkg::t_cmd  o_cmd,
    output logic            o_in_stall
);

    ffea_pkg::t_state  r_state, n_state;
    ffea_pkg::t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ffea_pkg::S_IDLE;
            r_status <= ffea_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_stall = (r_state != ffea_pkg::S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        case (r_state)
            ffea_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_status   = ffea_pkg::ST_OK;
                    case (i_action)
                        ffea_pkg::ACT_REG: begin
                            if (i_stat.full) begin
                                n_status = ffea_pkg::ST_FULL;
                                n_state  = ffea_pkg::S_DONE;
                            end else if (i_stat.count_zero) begin
                                n_state = ffea_pkg::S_INS_PLACE;
                            end else begin
                                n_state = ffea_pkg::S_INS_CHK;
                            end
                        end
                        ffea_pkg::ACT_UNREG: begin
                            if (i_stat.count_zero) begin
                                n_status = ffea_pkg::ST_NOT_FOUND;
                                n_state  = ffea_pkg::S_DONE;
                            end else begin
                                n_state = ffea_pkg::S_DEL_SCAN;
                            end
                        end
                        ffea_pkg::ACT_FIND: begin
                            if (i_stat.count_zero) begin
                                n_status = ffea_pkg::ST_NO_FIT;
                                n_state  = ffea_pkg::S_DONE;
                            end else begin
                                n_state = ffea_pkg::S_FIND_FIRST;
                            end
                        end
                        default: begin
                            n_state = ffea_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ffea_pkg::S_INS_CHK: begin
                if (i_stat.ins_move) begin
                    o_cmd.shift_up = 1'b1;
                    o_cmd.idx_dec  = 1'b1;
                    if (i_stat.idx_zero) begin
                        n_state = ffea_pkg::S_INS_PLACE;
                    end else begin
                        o_cmd.rd_prev = 1'b1;
                    end
                end else begin
                    o_cmd.place   = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = ffea_pkg::S_DONE;
                end
            end
            ffea_pkg::S_INS_PLACE: begin
                o_cmd.place   = 1'b1;
                o_cmd.cnt_inc = 1'b1;
                n_state       = ffea_pkg::S_DONE;
            end
            ffea_pkg::S_DEL_SCAN: begin
                o_cmd.rd_next = 1'b1;
                if (i_stat.del_match) begin
                    if (i_stat.idx_last) begin
                        o_cmd.cnt_dec = 1'b1;
                        n_state       = ffea_pkg::S_DONE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ffea_pkg::S_DEL_SHIFT;
                    end
                end else if (i_stat.idx_last) begin
                    n_status = ffea_pkg::ST_NOT_FOUND;
                    n_state  = ffea_pkg::S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ffea_pkg::S_DEL_SHIFT: begin
                o_cmd.shift_down = 1'b1;
                o_cmd.rd_next    = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = ffea_pkg::S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ffea_pkg::S_FIND_FIRST: begin
                o_cmd.run_first = 1'b1;
                o_cmd.rd_next   = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = ffea_pkg::S_FIND_TAIL;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ffea_pkg::S_FIND_STEP;
                end
            end
            ffea_pkg::S_FIND_STEP: begin
                o_cmd.rd_next = 1'b1;
                if (!i_stat.overlap && i_stat.gap_fit) begin
                    o_cmd.fit_take = 1'b1;
                    n_state        = ffea_pkg::S_DONE;
                end else begin
                    o_cmd.run_step = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = ffea_pkg::S_FIND_TAIL;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end
            end
            ffea_pkg::S_FIND_TAIL: begin
                if (i_stat.tail_fit) begin
                    o_cmd.fit_take = 1'b1;
                end else begin
                    n_status = ffea_pkg::ST_NO_FIT;
                end
                n_state = ffea_pkg::S_DONE;
            end
            ffea_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ffea_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ffea_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/ffea_dp.sv
module ffea_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ffea_pkg::t_in   i_in,
    input  logic [31:0]     i_area_end,
    input  ffea_pkg::t_cmd  i_cmd,
    input  logic            i_out_stall,
    output ffea_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output ffea_pkg::t_out  o_out
);

    localparam int AW = ffea_pkg::ADDR_W;
    localparam int CW = ffea_pkg::CNT_W;

    ffea_pkg::t_entry mem [ffea_pkg::DEPTH];
    ffea_pkg::t_entry r_q;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [31:0]   r_start;
    logic [31:0]   r_len;
    logic [32:0]   r_stop;
    logic [32:0]   r_run;
    logic [32:0]   r_fit;
    logic          r_out_valid;
    ffea_pkg::t_out r_out;

    logic [CW-1:0] n_rd_idx;
    logic [CW-1:0] w_idx_inc;
    logic [CW-1:0] w_idx_dec;
    logic          w_en;
    logic [CW-1:0] w_idx;
    ffea_pkg::t_entry w_data;
    logic [32:0]   w_first;
    logic [32:0]   w_area;
    logic [32:0]   w_len;
    logic [32:0]   w_gap;
    logic [32:0]   w_tail;

    assign w_idx_inc = r_idx + CW'(1);
    assign w_idx_dec = r_idx - CW'(1);
    assign w_first   = {1'b0, r_q.first};
    assign w_area    = {1'b0, i_area_end};
    assign w_len     = {1'b0, r_len};
    assign w_gap     = w_first - r_run;
    assign w_tail    = w_area - r_run;

    always_comb begin
        if (i_cmd.load) begin
            n_rd_idx = (i_in.action == ffea_pkg::ACT_REG) ? (r_count - CW'(1)) : '0;
        end else if (i_cmd.rd_next || i_cmd.idx_inc) begin
            n_rd_idx = w_idx_inc;
        end else if (i_cmd.rd_prev || i_cmd.idx_dec) begin
            n_rd_idx = w_idx_dec;
        end else begin
            n_rd_idx = r_idx;
        end
    end

    always_comb begin
        w_en   = 1'b0;
        w_idx  = w_idx_inc;
        w_data = r_q;
        if (i_cmd.shift_up) begin
            w_en = 1'b1;
        end else if (i_cmd.place) begin
            w_en         = 1'b1;
            w_data.first = r_start;
            w_data.stop  = r_stop;
        end else if (i_cmd.shift_down) begin
            w_en  = 1'b1;
            w_idx = w_idx_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_idx[AW-1:0]] <= w_data;
        end
        r_q <= mem[n_rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_in.start_req;
            r_len   <= i_in.length;
            r_stop  <= {1'b0, i_in.start_req} + {1'b0, i_in.length};
            r_fit   <= '0;
        end else if (i_cmd.fit_take) begin
            r_fit <= r_run;
        end
        r_idx <= n_rd_idx;
        if (i_cmd.run_first) begin
            r_run <= r_q.stop;
        end else if (i_cmd.run_step) begin
            if (o_stat.overlap) begin
                r_run <= (r_q.stop > r_run) ? r_q.stop : r_run;
            end else begin
                r_run <= r_q.stop;
            end
        end
        if (i_cmd.emit) begin
            r_out.status     <= i_cmd.status;
            r_out.fit_start  <= r_fit;
            r_out.used_count <= r_count;
        end
    end

    always_comb begin
        o_stat.count_zero = (r_count == '0);
        o_stat.full       = (r_count == CW'(ffea_pkg::DEPTH));
        o_stat.idx_last   = (w_idx_inc == r_count);
        o_stat.idx_zero   = (r_idx == '0);
        o_stat.ins_move   = (r_q.first > r_start);
        o_stat.del_match  = (r_q.first == r_start) && (r_q.stop == r_stop);
        o_stat.overlap    = (w_first <= r_run);
        o_stat.gap_fit    = (w_gap >= w_len);
        o_stat.tail_fit   = (w_area > r_run) && (w_tail >= w_len);
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/core/first_fit_extent_allocator.sv
// Channel   Dir  Handshake              Beat
// in        in   i_in_valid/o_in_stall  t_in: action, start_req, length
// out       out  o_out_valid/i_out_stall t_out: status, fit_start, used_count
// cfg       in   APB psel/penable        area_end at byte address 0
//
// One item at a time through a table of 64 sorted extents (one read, one write port).
// Register shifts larger entries up, then places; unregister scans for a match
// and shifts later entries down; find walks the entries for a gap, else the tail.
// The walk reads the entries one at a time through the table read port.
// Reset empties the table; no clearing pass.
// A result waits in the output register while the next item may enter.
module first_fit_extent_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ffea_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ffea_pkg::t_out                   o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ffea_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic [31:0]     r_area_end;
    ffea_pkg::t_cmd  w_cmd;
    ffea_pkg::t_stat w_stat;

    assign pready = 1'b1;
    assign prdata = r_area_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_area_end <= '0;
        end else if (psel && penable && pwrite && (paddr == '0)) begin
            r_area_end <= pwdata;
        end
    end

    ffea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in.action),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    ffea_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_area_end  (r_area_end),
        .i_cmd       (w_cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

### rtl/core/ffea_checker.sv
module ffea_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input ffea_pkg::t_out o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.used_count <= ffea_pkg::CNT_W'(ffea_pkg::DEPTH))
        else $error("used count past table size");

    a_fit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ffea_pkg::ST_OK) |-> o_out.fit_start == '0)
        else $error("fit start set on failure");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ffea_pkg::ST_FULL)
        |-> o_out.used_count == ffea_pkg::CNT_W'(ffea_pkg::DEPTH))
        else $error("full reported below capacity");

endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
